>>> rtl/bhr_pkg.sv
package bhr_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int WORD_W           = 32;
   localparam int COUNT_W          = 6;
   localparam int ENTRY_W          = 2 * WORD_W;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_NEWER  = 2'd1,
      CMD_OLDER  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [WORD_W-1:0]   entry_data;
      logic [WORD_W-1:0]   entry_time;
   } req_type;

   typedef struct packed {
      logic                has_entry;
      logic [WORD_W-1:0]   active_id;
      logic [WORD_W-1:0]   active_data;
      logic [WORD_W-1:0]   active_time;
      logic [COUNT_W-1:0]  position;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

endpackage

>>> rtl/bhr_ring_mem.sv
module bhr_ring_mem #(
   parameter int DEPTH  = bhr_pkg::CAPACITY_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [bhr_pkg::ENTRY_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [bhr_pkg::ENTRY_W-1:0] rd_data
);
   import bhr_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_q_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic               fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

>>> rtl/bounded_history_ring_with_cursor_top.sv
// History ring of up to CAPACITY entries (id, data word, timestamp) with a
// viewing cursor. Each request carries one command: append, cursor newer,
// cursor older or clear; each yields exactly one response describing the
// entry under the cursor after the command, its 1-based position and the
// entry count. Append ids come from a counter that starts at 1 and survives
// clear. Pointers update and the store is written at the accept edge while the
// cursor slot is read, and the response register loads from the registered
// store read in the following cycle; no new request is taken while one is
// pending or an unaccepted response is held. No clearing pass follows reset.
module bounded_history_ring_with_cursor_top #(
   parameter int CAPACITY = bhr_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bhr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bhr_pkg::rsp_type rsp_payload
);
   import bhr_pkg::*;

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [SLOT_W-1:0] oldest_slot_ff, oldest_slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;
   logic [WORD_W-1:0] oldest_id_ff, oldest_id_in;
   logic [WORD_W-1:0] next_id_ff, next_id_in;

   logic              pend_ff;
   logic              pend_has_ff;
   logic [WORD_W-1:0] pend_id_ff;
   logic [COUNT_W-1:0] pend_pos_ff;
   logic [COUNT_W-1:0] pend_cnt_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              accept;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_slot;
   logic [SLOT_W-1:0] rd_slot;
   logic [SUM_W-1:0]  wr_sum;
   logic [SUM_W-1:0]  rd_sum;
   logic [ENTRY_W-1:0] rd_data;

   assign req_ready = !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      wr_sum = SUM_W'(oldest_slot_ff) + SUM_W'(count_ff);
      if (wr_sum >= CAP_SUM) begin
         wr_sum = wr_sum - CAP_SUM;
      end
      wr_slot = wr_sum[SLOT_W-1:0];
   end

   always_comb begin
      oldest_slot_in = oldest_slot_ff;
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      oldest_id_in   = oldest_id_ff;
      next_id_in     = next_id_ff;
      wr_en          = 1'b0;
      case (req_payload.cmd)
         CMD_APPEND: begin
            wr_en      = 1'b1;
            next_id_in = next_id_ff + 1'b1;
            if (count_ff == '0) begin
               oldest_id_in = next_id_ff;
               cursor_in    = '0;
            end
            if (count_ff == CAP_CNT) begin
               if (SUM_W'(oldest_slot_ff) + 1'b1 >= CAP_SUM) begin
                  oldest_slot_in = '0;
               end else begin
                  oldest_slot_in = oldest_slot_ff + 1'b1;
               end
               oldest_id_in = oldest_id_ff + 1'b1;
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - 1'b1;
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         CMD_NEWER: begin
            if (CNT_W'(cursor_ff) + 1'b1 < count_ff) begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         CMD_OLDER: begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in       = '0;
            cursor_in      = '0;
            oldest_slot_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rd_sum = SUM_W'(oldest_slot_in) + SUM_W'(cursor_in);
      if (rd_sum >= CAP_SUM) begin
         rd_sum = rd_sum - CAP_SUM;
      end
      rd_slot = rd_sum[SLOT_W-1:0];
   end

   bhr_ring_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SLOT_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_slot),
      .wr_data ({req_payload.entry_data, req_payload.entry_time}),
      .rd_en   (accept),
      .rd_addr (rd_slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_slot_ff <= '0;
         count_ff       <= '0;
         cursor_ff      <= '0;
         oldest_id_ff   <= '0;
         next_id_ff     <= WORD_W'(1);
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            oldest_slot_ff <= oldest_slot_in;
            count_ff       <= count_in;
            cursor_ff      <= cursor_in;
            oldest_id_ff   <= oldest_id_in;
            next_id_ff     <= next_id_in;
         end
         pend_ff <= accept;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_has_ff <= (count_in != '0);
         pend_id_ff  <= oldest_id_in + WORD_W'(cursor_in);
         pend_pos_ff <= COUNT_W'(CNT_W'(cursor_in) + 1'b1);
         pend_cnt_ff <= COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_ff.has_entry   <= pend_has_ff;
         rsp_ff.active_id   <= pend_has_ff ? pend_id_ff : '0;
         rsp_ff.active_data <= pend_has_ff ? rd_data[ENTRY_W-1:WORD_W] : '0;
         rsp_ff.active_time <= pend_has_ff ? rd_data[WORD_W-1:0] : '0;
         rsp_ff.position    <= pend_has_ff ? pend_pos_ff : '0;
         rsp_ff.entry_count <= pend_has_ff ? pend_cnt_ff : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
